/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge, held off while reset is low
`define AFS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every rising edge, reset included
`define AFS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/afs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Word types, queue command type and constants of the ADTS frame splitter.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int AFS_HDR_LEN  = 7;
  localparam int AFS_HDR_BITS = 8 * AFS_HDR_LEN;
  localparam logic [2:0] AFS_HDR_LAST_IDX = 3'(AFS_HDR_LEN - 1);
  localparam logic [7:0] AFS_SYNC_BYTE = 8'hFF;
  localparam logic [3:0] AFS_SYNC_NIBBLE = 4'hF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_first;
    logic       buffer_last;
  } afs_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_first;
    logic        frame_last;
    logic        truncated;
    logic        sync_error;
    logic        mpeg_id;
    logic        no_crc;
    logic [1:0]  profile;
    logic [3:0]  sample_rate_index;
    logic [2:0]  channel_config;
    logic [12:0] frame_length;
    logic [1:0]  raw_blocks;
  } afs_out_t;

  typedef enum logic [1:0] {
    AFS_CMD_HDR  = 2'd0,
    AFS_CMD_BODY = 2'd1,
    AFS_CMD_ERR  = 2'd2
  } afs_kind_t;

  typedef struct packed {
    afs_kind_t                kind;
    logic [7:0]               data_byte;
    logic                     last;
    logic                     trunc;
    logic [AFS_HDR_BITS-1:0]  hdr;
  } afs_cmd_t;

endpackage

/* rtl/core/afs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_front
// Sync hunt, header gathering and body counting; pushes one command per
// finished header, body byte or bad header (sync or length) into the queue.
// ----------------------------------------------------------------------------
module afs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  afs_pkg::afs_in_t   in_data,
  input  logic               q_ready,
  output logic               push_valid,
  output afs_pkg::afs_cmd_t  push_cmd
);

  typedef enum logic [3:0] {
    MODE_HALT   = 4'b0001,
    MODE_HUNT   = 4'b0010,
    MODE_HEADER = 4'b0100,
    MODE_BODY   = 4'b1000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        pwf_r, pwf_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [12:0] br_r, br_nxt;
  logic [7:0]  hdr_r [afs_pkg::AFS_HDR_LEN];

  logic        accept;
  mode_t       mode_v;
  logic        pwf_v;
  logic [2:0]  hc_v;
  logic [12:0] br_v;
  logic [12:0] br_dec;
  logic [12:0] len;
  logic        sync_ok;
  logic        hdr_wr_en;
  logic        sync_hit;
  logic [afs_pkg::AFS_HDR_BITS-1:0] hdr_cur;
  logic [afs_pkg::AFS_HDR_BITS-1:0] hdr_done;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  assign hdr_cur  = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3], hdr_r[4], hdr_r[5], hdr_r[6]};
  assign hdr_done = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3], hdr_r[4], hdr_r[5],
                     in_data.data_byte};
  assign len      = {hdr_r[3][1:0], hdr_r[4], hdr_r[5][7:5]};
  assign sync_ok  = (hdr_r[0] == afs_pkg::AFS_SYNC_BYTE) &&
                    (hdr_r[1][7:4] == afs_pkg::AFS_SYNC_NIBBLE);

  always_comb begin
    mode_v    = in_data.buffer_first ? MODE_HUNT : mode_r;
    pwf_v     = in_data.buffer_first ? 1'b0 : pwf_r;
    hc_v      = in_data.buffer_first ? 3'd0 : hc_r;
    br_v      = in_data.buffer_first ? 13'd0 : br_r;
    br_dec    = br_v - 13'd1;
    mode_nxt  = mode_r;
    pwf_nxt   = pwf_r;
    hc_nxt    = hc_r;
    br_nxt    = br_r;
    hdr_wr_en = 1'b0;
    sync_hit  = 1'b0;
    push_valid         = 1'b0;
    push_cmd.kind      = afs_pkg::AFS_CMD_BODY;
    push_cmd.data_byte = in_data.data_byte;
    push_cmd.last      = 1'b0;
    push_cmd.trunc     = 1'b0;
    push_cmd.hdr       = hdr_cur;
    if (accept) begin
      mode_nxt = mode_v;
      pwf_nxt  = pwf_v;
      hc_nxt   = hc_v;
      br_nxt   = br_v;
      unique case (mode_v)
        MODE_HUNT: begin
          if (pwf_v && (in_data.data_byte[7:4] == afs_pkg::AFS_SYNC_NIBBLE)) begin
            sync_hit = 1'b1;
            hc_nxt   = 3'd2;
            pwf_nxt  = 1'b0;
            mode_nxt = MODE_HEADER;
          end else begin
            pwf_nxt = (in_data.data_byte == afs_pkg::AFS_SYNC_BYTE);
          end
        end
        MODE_HEADER: begin
          hdr_wr_en = 1'b1;
          if (hc_v == afs_pkg::AFS_HDR_LAST_IDX) begin
            hc_nxt     = 3'd0;
            push_valid = 1'b1;
            if (!sync_ok || (len < 13'(afs_pkg::AFS_HDR_LEN))) begin
              push_cmd.kind = afs_pkg::AFS_CMD_ERR;
              mode_nxt      = MODE_HALT;
            end else begin
              push_cmd.kind = afs_pkg::AFS_CMD_HDR;
              push_cmd.hdr  = hdr_done;
              if (len == 13'(afs_pkg::AFS_HDR_LEN)) begin
                push_cmd.last = 1'b1;
                mode_nxt      = MODE_HEADER;
              end else begin
                br_nxt         = len - 13'(afs_pkg::AFS_HDR_LEN);
                mode_nxt       = MODE_BODY;
                push_cmd.last  = in_data.buffer_last;
                push_cmd.trunc = in_data.buffer_last;
              end
            end
          end else begin
            hc_nxt = hc_v + 3'd1;
          end
        end
        MODE_BODY: begin
          br_nxt     = br_dec;
          push_valid = 1'b1;
          if (br_dec == 13'd0) begin
            push_cmd.last = 1'b1;
            mode_nxt      = MODE_HEADER;
            hc_nxt        = 3'd0;
          end else begin
            push_cmd.last  = in_data.buffer_last;
            push_cmd.trunc = in_data.buffer_last;
          end
        end
        default: begin
        end
      endcase
      if (in_data.buffer_last) begin
        mode_nxt = MODE_HALT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HALT;
      pwf_r  <= 1'b0;
      hc_r   <= 3'd0;
      br_r   <= 13'd0;
    end else begin
      mode_r <= mode_nxt;
      pwf_r  <= pwf_nxt;
      hc_r   <= hc_nxt;
      br_r   <= br_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sync_hit) begin
      hdr_r[0] <= afs_pkg::AFS_SYNC_BYTE;
      hdr_r[1] <= in_data.data_byte;
    end else if (hdr_wr_en) begin
      hdr_r[hc_v] <= in_data.data_byte;
    end
  end

endmodule

/* rtl/core/afs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_queue
// Command queue between front and back; absorbs the header bursts. The head
// entry is read ahead into a register, with bypass on a write to it.
// ----------------------------------------------------------------------------
module afs_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  afs_pkg::afs_cmd_t  push_cmd,
  output logic               push_ready,
  output logic               pop_valid,
  output afs_pkg::afs_cmd_t  pop_cmd,
  input  logic               pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  afs_pkg::afs_cmd_t mem [DEPTH];
  afs_pkg::afs_cmd_t head_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = head_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_cmd;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

/* rtl/core/afs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_back
// Expands queued commands into result words: seven words per header, one per
// body byte or error, through a registered output stage.
// ----------------------------------------------------------------------------
module afs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  afs_pkg::afs_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output afs_pkg::afs_out_t  out_data
);

  function automatic afs_pkg::afs_out_t hdr_fields(
    input logic [afs_pkg::AFS_HDR_BITS-1:0] h
  );
    afs_pkg::afs_out_t f;
    f = '0;
    f.mpeg_id           = h[43];
    f.no_crc            = h[40];
    f.profile           = h[39:38];
    f.sample_rate_index = h[37:34];
    f.channel_config    = {h[32], h[31:30]};
    f.frame_length      = {h[25:24], h[23:16], h[15:13]};
    f.raw_blocks        = h[1:0];
    return f;
  endfunction

  function automatic logic [7:0] hdr_byte(
    input logic [afs_pkg::AFS_HDR_BITS-1:0] h,
    input logic [2:0] idx
  );
    logic [7:0] b;
    case (idx)
      3'd0:    b = h[55:48];
      3'd1:    b = h[47:40];
      3'd2:    b = h[39:32];
      3'd3:    b = h[31:24];
      3'd4:    b = h[23:16];
      3'd5:    b = h[15:8];
      default: b = h[7:0];
    endcase
    return b;
  endfunction

  logic [2:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  afs_pkg::afs_out_t out_data_r;
  afs_pkg::afs_out_t res;
  logic              advance;
  logic              hdr_end;

  assign advance   = cmd_valid && (!out_valid_r || out_ready);
  assign hdr_end   = (idx_r == afs_pkg::AFS_HDR_LAST_IDX);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    res     = hdr_fields(cmd.hdr);
    cmd_pop = 1'b0;
    idx_nxt = idx_r;
    unique case (cmd.kind)
      afs_pkg::AFS_CMD_HDR: begin
        res.out_byte    = hdr_byte(cmd.hdr, idx_r);
        res.frame_first = (idx_r == 3'd0);
        res.frame_last  = hdr_end && cmd.last;
        res.truncated   = hdr_end && cmd.trunc;
        if (advance) begin
          cmd_pop = hdr_end;
          idx_nxt = hdr_end ? 3'd0 : idx_r + 3'd1;
        end
      end
      afs_pkg::AFS_CMD_BODY: begin
        res.out_byte   = cmd.data_byte;
        res.frame_last = cmd.last;
        res.truncated  = cmd.trunc;
        cmd_pop        = advance;
      end
      afs_pkg::AFS_CMD_ERR: begin
        res            = '0;
        res.sync_error = 1'b1;
        cmd_pop        = advance;
      end
      default: begin
        res     = '0;
        cmd_pop = advance;
      end
    endcase
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule

/* rtl/core/adts_frame_splitter_unit.sv */
// Path: a body byte's word goes through the queue head register, then the
// output register; the seven header words follow the last header byte the same way.
// Throughput: one byte per cycle while the QUEUE_DEPTH-entry command queue has
// room; it absorbs the 7-word header burst paced by the single output register.
// Reset: synchronous on rst_n low; the block then drops bytes until a byte
// with buffer_first, and the output register comes up empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_frame_splitter_unit
// ADTS frame splitter: front parser, command queue and result back end.
// ----------------------------------------------------------------------------
module adts_frame_splitter_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  afs_pkg::afs_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output afs_pkg::afs_out_t  out_data
);

  logic              push_valid;
  afs_pkg::afs_cmd_t push_cmd;
  logic              q_ready;
  logic              q_valid;
  afs_pkg::afs_cmd_t q_cmd;
  logic              q_pop;

  afs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_ready    (q_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  afs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  afs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/afs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks on the result channel of the ADTS frame splitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input afs_pkg::afs_out_t out_data
);

  `AFS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")
  `AFS_ASSERT(a_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid, "valid dropped")
  `AFS_ASSERT(a_err_clean, clk, rst_n, out_valid && out_data.sync_error |-> out_data.out_byte == 8'd0 && !out_data.frame_first && !out_data.frame_last, "error word carries data")
  `AFS_ASSERT(a_trunc_last, clk, rst_n, out_valid && out_data.truncated |-> out_data.frame_last, "truncated without frame_last")
  `AFS_ASSERT(a_first_hdr, clk, rst_n, out_valid && out_data.frame_first |-> out_data.out_byte == 8'hFF && out_data.frame_length >= 13'd7, "bad frame start word")

endmodule

bind adts_frame_splitter_unit afs_checker u_afs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the ADTS frame splitter against an in-bench frame predictor. Byte
// buffers with directed and random ADTS frames go in, mostly under random input
// gaps and output stalls; every emitted word is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum logic [3:0] {
    ST_HALT   = 4'b0001,
    ST_HUNT   = 4'b0010,
    ST_HEADER = 4'b0100,
    ST_BODY   = 4'b1000
  } split_state_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  afs_pkg::afs_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  afs_pkg::afs_out_t out_data;

  afs_pkg::afs_out_t frame_words_q[$];
  logic [7:0]        buffer_q[$];
  split_state_t      split_mode;
  logic              seen_ff;
  logic [7:0]        hdr_bytes[afs_pkg::AFS_HDR_LEN];
  int                hdr_fill;
  logic [12:0]       body_left;
  bit                steady;
  int                mismatch_count;

  adts_frame_splitter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [12:0] header_frame_length();
    return {hdr_bytes[3][1:0], hdr_bytes[4], hdr_bytes[5][7:5]};
  endfunction

  function automatic afs_pkg::afs_out_t frame_word(logic [7:0] b, logic f, logic l,
                                                   logic t);
    afs_pkg::afs_out_t r;
    r = '0;
    r.out_byte          = b;
    r.frame_first       = f;
    r.frame_last        = l;
    r.truncated         = t;
    r.mpeg_id           = hdr_bytes[1][3];
    r.no_crc            = hdr_bytes[1][0];
    r.profile           = hdr_bytes[2][7:6];
    r.sample_rate_index = hdr_bytes[2][5:2];
    r.channel_config    = {hdr_bytes[2][0], hdr_bytes[3][7:6]};
    r.frame_length      = header_frame_length();
    r.raw_blocks        = hdr_bytes[6][1:0];
    return r;
  endfunction

  task automatic predict_frame_words(input afs_pkg::afs_in_t w);
    logic [12:0]       len;
    afs_pkg::afs_out_t r;
    if (w.buffer_first) begin
      split_mode = ST_HUNT;
      seen_ff    = 1'b0;
      hdr_fill   = 0;
      body_left  = '0;
    end
    case (split_mode)
      ST_HUNT: begin
        if (seen_ff && w.data_byte[7:4] == afs_pkg::AFS_SYNC_NIBBLE) begin
          hdr_bytes[0] = afs_pkg::AFS_SYNC_BYTE;
          hdr_bytes[1] = w.data_byte;
          hdr_fill     = 2;
          seen_ff      = 1'b0;
          split_mode   = ST_HEADER;
        end else begin
          seen_ff = (w.data_byte == afs_pkg::AFS_SYNC_BYTE);
        end
      end
      ST_HEADER: begin
        hdr_bytes[hdr_fill] = w.data_byte;
        hdr_fill++;
        if (hdr_fill == afs_pkg::AFS_HDR_LEN) begin
          hdr_fill = 0;
          len = header_frame_length();
          if ({hdr_bytes[0], hdr_bytes[1][7:4]} !=
              {afs_pkg::AFS_SYNC_BYTE, afs_pkg::AFS_SYNC_NIBBLE} ||
              len < afs_pkg::AFS_HDR_LEN) begin
            r = '0;
            r.sync_error = 1'b1;
            frame_words_q.push_back(r);
            split_mode = ST_HALT;
          end else begin
            for (int k = 0; k < afs_pkg::AFS_HDR_LEN; k++) begin
              r = frame_word(hdr_bytes[k], k == 0, 1'b0, 1'b0);
              if (k == afs_pkg::AFS_HDR_LEN - 1) begin
                if (len == afs_pkg::AFS_HDR_LEN) begin
                  r.frame_last = 1'b1;
                end else if (w.buffer_last) begin
                  r.frame_last = 1'b1;
                  r.truncated  = 1'b1;
                end
              end
              frame_words_q.push_back(r);
            end
            if (len != afs_pkg::AFS_HDR_LEN) begin
              body_left  = len - 13'(afs_pkg::AFS_HDR_LEN);
              split_mode = ST_BODY;
            end
          end
        end
      end
      ST_BODY: begin
        body_left = body_left - 13'd1;
        if (body_left == '0) begin
          frame_words_q.push_back(frame_word(w.data_byte, 1'b0, 1'b1, 1'b0));
          split_mode = ST_HEADER;
          hdr_fill   = 0;
        end else begin
          frame_words_q.push_back(frame_word(w.data_byte, 1'b0, w.buffer_last,
                                             w.buffer_last));
        end
      end
      default: ;
    endcase
    if (w.buffer_last) split_mode = ST_HALT;
  endtask

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input afs_pkg::afs_in_t w);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_frame_words(w);
    @(negedge clk);
  endtask

  task automatic send_buffer(input bit mark_first, input bit mark_last);
    afs_pkg::afs_in_t w;
    for (int i = 0; i < buffer_q.size(); i++) begin
      w.data_byte    = buffer_q[i];
      w.buffer_first = mark_first && i == 0;
      w.buffer_last  = mark_last && i == buffer_q.size() - 1;
      send_word(w);
    end
    buffer_q.delete();
  endtask

  task automatic add_header(input logic id, input logic prot, input logic [1:0] prof,
                            input logic [3:0] sri, input logic [2:0] ch,
                            input logic [12:0] len, input logic [1:0] raw);
    logic [10:0] fullness;
    fullness = 11'($urandom_range(0, 2047));
    buffer_q.push_back(afs_pkg::AFS_SYNC_BYTE);
    buffer_q.push_back({afs_pkg::AFS_SYNC_NIBBLE, id, 2'($urandom_range(0, 3)), prot});
    buffer_q.push_back({prof, sri, 1'($urandom_range(0, 1)), ch[2]});
    buffer_q.push_back({ch[1:0], 4'($urandom_range(0, 15)), len[12:11]});
    buffer_q.push_back(len[10:3]);
    buffer_q.push_back({len[2:0], fullness[10:6]});
    buffer_q.push_back({fullness[5:0], raw});
  endtask

  task automatic add_random_header(input logic [12:0] len);
    add_header(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
               3'($urandom_range(0, 7)), len, 2'($urandom_range(0, 3)));
  endtask

  task automatic check_field(input string name, input logic [12:0] exp_v,
                             input logic [12:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    afs_pkg::afs_out_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (frame_words_q.size() == 0) begin
        $error("out_byte: expected no word, got %0d", out_data.out_byte);
        mismatch_count++;
      end else begin
        exp_w = frame_words_q.pop_front();
        check_field("out_byte", 13'(exp_w.out_byte), 13'(out_data.out_byte));
        check_field("frame_first", 13'(exp_w.frame_first), 13'(out_data.frame_first));
        check_field("frame_last", 13'(exp_w.frame_last), 13'(out_data.frame_last));
        check_field("truncated", 13'(exp_w.truncated), 13'(out_data.truncated));
        check_field("sync_error", 13'(exp_w.sync_error), 13'(out_data.sync_error));
        check_field("mpeg_id", 13'(exp_w.mpeg_id), 13'(out_data.mpeg_id));
        check_field("no_crc", 13'(exp_w.no_crc), 13'(out_data.no_crc));
        check_field("profile", 13'(exp_w.profile), 13'(out_data.profile));
        check_field("sample_rate_index", 13'(exp_w.sample_rate_index),
                    13'(out_data.sample_rate_index));
        check_field("channel_config", 13'(exp_w.channel_config),
                    13'(out_data.channel_config));
        check_field("frame_length", exp_w.frame_length, out_data.frame_length);
        check_field("raw_blocks", 13'(exp_w.raw_blocks), 13'(out_data.raw_blocks));
      end
    end
  end

  initial begin
    int n;
    int r;
    @(negedge clk);
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (r < 90) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(15, 40);
        end
      end
      repeat (n) @(negedge clk);
    end
  end

  task automatic test_halted_bytes();
    buffer_q = '{afs_pkg::AFS_SYNC_BYTE, 8'hF1};
    send_buffer(1'b0, 1'b0);
  endtask

  task automatic test_buffer_end_in_hunt_and_header();
    buffer_q = '{afs_pkg::AFS_SYNC_BYTE, 8'h0F};
    send_buffer(1'b1, 1'b1);
    buffer_q = '{afs_pkg::AFS_SYNC_BYTE, 8'hF1, 8'h50};
    send_buffer(1'b1, 1'b1);
  endtask

  task automatic test_chained_frames();
    add_header(1'b1, 1'b0, 2'd1, 4'd4, 3'd2, 13'd7, 2'd0);
    add_header(1'b0, 1'b0, 2'd0, 4'd0, 3'd0, 13'd9, 2'd0);
    send_buffer(1'b1, 1'b1);
  endtask

  task automatic test_restart_and_short_length();
    buffer_q = '{afs_pkg::AFS_SYNC_BYTE, 8'hF1, 8'h00};
    send_buffer(1'b1, 1'b0);
    add_random_header(13'd3);
    send_buffer(1'b1, 1'b0);
  endtask

  task automatic test_max_fields_truncated();
    add_header(1'b1, 1'b1, 2'd3, 4'd15, 3'd7, 13'd8191, 2'd3);
    buffer_q.push_back(8'hFF);
    buffer_q.push_back(8'h00);
    send_buffer(1'b1, 1'b1);
  endtask

  task automatic build_random_buffer();
    int nframes;
    int len;
    int r;
    int cut;
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) buffer_q.push_back(8'($urandom_range(0, 255)));
    nframes = $urandom_range(1, 4);
    for (int k = 0; k < nframes; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 7;
      else if (r < 80) len = $urandom_range(8, 24);
      else if (r < 88) len = $urandom_range(0, 6);
      else len = $urandom_range(0, 8191);
      add_random_header(13'(len));
      if (k > 0 && $urandom_range(0, 14) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          buffer_q[buffer_q.size() - 7] = 8'($urandom_range(0, 254));
        end else begin
          b = buffer_q[buffer_q.size() - 6];
          b[7:4] = 4'($urandom_range(0, 14));
          buffer_q[buffer_q.size() - 6] = b;
        end
      end
      if (len > 24) begin
        repeat ($urandom_range(0, 6)) buffer_q.push_back(8'($urandom_range(0, 255)));
        break;
      end
      if (len > 7) begin
        repeat (len - 7) buffer_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, buffer_q.size());
      while (buffer_q.size() > cut) void'(buffer_q.pop_back());
    end
  endtask

  task automatic run_random_buffers(input int target);
    int sent;
    bit closed;
    sent = 0;
    while (sent < target) begin
      build_random_buffer();
      sent += buffer_q.size();
      closed = ($urandom_range(0, 9) != 0);
      send_buffer(1'b1, closed);
      if (closed && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) buffer_q.push_back(8'($urandom_range(0, 255)));
        send_buffer(1'b0, 1'b0);
      end
    end
  endtask

  task automatic test_random_streams();
    run_random_buffers(160);
  endtask

  task automatic test_steady_streams();
    steady = 1'b1;
    run_random_buffers(40);
    steady = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    steady         = 1'b0;
    mismatch_count = 0;
    split_mode     = ST_HALT;
    seen_ff        = 1'b0;
    hdr_fill       = 0;
    body_left      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_halted_bytes();
    test_buffer_end_in_hunt_and_header();
    test_chained_frames();
    test_restart_and_short_length();
    test_max_fields_truncated();
    test_random_streams();
    test_steady_streams();

    in_valid <= 1'b0;
    while (frame_words_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
